@@ hw/rtl/stun_pkg.sv @@
// ----------------------------------------------------------------------------
// STUN parser package
// Types, codes and constants shared by the STUN message parser modules.
// ----------------------------------------------------------------------------
package stun_pkg;

  // Header and counter limits.
  localparam logic [16:0] HDR_BYTES   = 17'd20;
  localparam logic [16:0] COUNT_MAX   = 17'h1FFFF;
  localparam logic [7:0]  TYPE0_LIMIT = 8'd3;

  // Method decode: the class bits are masked out, binding is method 1.
  localparam logic [15:0] METHOD_MASK    = 16'h3EEF;
  localparam logic [15:0] METHOD_BINDING = 16'h0001;

  // Depth of the result queue; it must hold the two results of one byte.
  localparam int unsigned Q_DEPTH = 4;

  // Configuration register indexes.
  localparam logic REG_COOKIE = 1'b0;
  localparam logic REG_TARGET = 1'b1;

  // Result kinds.
  localparam logic KIND_ATTR    = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  // Summary status codes.
  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_SHORT      = 3'd1;
  localparam logic [2:0] ST_BAD_HEADER = 3'd2;
  localparam logic [2:0] ST_LEN_MISM   = 3'd3;
  localparam logic [2:0] ST_UNTILED    = 3'd4;

  // Attribute walk state.
  typedef enum logic [2:0] {
    PH_HDR  = 3'b001,
    PH_VAL  = 3'b010,
    PH_STOP = 3'b100
  } phase_t;

  typedef struct packed {
    logic        kind;
    logic [15:0] attr_type;
    logic [15:0] attr_length;
    logic [15:0] attr_offset;
    logic        optional_attr;
    logic        is_match;
    logic [1:0]  stun_class;
    logic        method_binding;
    logic [2:0]  status;
    logic        last;
  } result_t;

  // Results produced by one byte: an attribute record, a summary, or both.
  typedef struct packed {
    logic    rec_valid;
    logic    sum_valid;
    result_t rec;
    result_t sum;
  } push_t;

  typedef struct packed {
    logic [$clog2(Q_DEPTH):0] count;
  } qstat_t;

endpackage

@@ hw/rtl/stun_ifs.sv @@
// ----------------------------------------------------------------------------
// STUN parser channels
// Valid/ready channels for datagram bytes in and parse results out.
// ----------------------------------------------------------------------------
interface stun_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_message;

  modport source (output valid, output data_byte, output end_of_message, input ready);
  modport sink (input valid, input data_byte, input end_of_message, output ready);
endinterface

interface stun_out_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [15:0] attr_type;
  logic [15:0] attr_length;
  logic [15:0] attr_offset;
  logic        optional_attr;
  logic        is_match;
  logic [1:0]  stun_class;
  logic        method_binding;
  logic [2:0]  status;
  logic        last;

  modport source (
    output valid, output kind, output attr_type, output attr_length, output attr_offset,
    output optional_attr, output is_match, output stun_class, output method_binding,
    output status, output last, input ready
  );
  modport sink (
    input valid, input kind, input attr_type, input attr_length, input attr_offset,
    input optional_attr, input is_match, input stun_class, input method_binding,
    input status, input last, output ready
  );
endinterface

@@ hw/rtl/stun_core.sv @@
// ----------------------------------------------------------------------------
// STUN parser core
// Per-byte header capture, attribute walk and summary generation.
// ----------------------------------------------------------------------------
module stun_core (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  logic [7:0]            data_byte,
  input  logic                  end_of_message,
  input  logic [31:0]           magic_cookie,
  input  logic [15:0]           target_type,
  output stun_pkg::push_t       push
);

  logic [16:0]      byte_count, byte_count_next;
  logic [15:0]      type_word, type_word_next;
  logic [15:0]      declared_length, declared_length_next;
  logic [31:0]      cookie_shift, cookie_shift_next;
  stun_pkg::phase_t attr_phase, attr_phase_next;
  logic [31:0]      attr_header_shift, attr_header_shift_next;
  logic [16:0]      attr_remaining, attr_remaining_next;
  logic [15:0]      attr_start, attr_start_next;
  logic             match_seen, match_seen_next;

  logic        hdr_ok, hdr_ok_next, walk_en, rec_hit, hit;
  logic [16:0] off17, pad;
  logic [15:0] off, rec_type;
  logic [17:0] attr_end;
  logic [2:0]  st;

  always_comb begin
    byte_count_next        = (byte_count != stun_pkg::COUNT_MAX) ? byte_count + 17'd1
                                                                 : byte_count;
    type_word_next         = type_word;
    declared_length_next   = declared_length;
    cookie_shift_next      = cookie_shift;
    attr_phase_next        = attr_phase;
    attr_header_shift_next = attr_header_shift;
    attr_remaining_next    = attr_remaining;
    attr_start_next        = attr_start;
    match_seen_next        = match_seen;
    rec_hit                = 1'b0;
    pad                    = '0;
    attr_end               = '0;

    hdr_ok  = (type_word[15:8] < stun_pkg::TYPE0_LIMIT) && (cookie_shift == magic_cookie);
    walk_en = (byte_count >= stun_pkg::HDR_BYTES)
           && (byte_count < stun_pkg::HDR_BYTES + {1'b0, declared_length}) && hdr_ok;
    off17   = byte_count - stun_pkg::HDR_BYTES;
    off     = off17[15:0];

    if (byte_count < 17'd2) begin
      type_word_next = {type_word[7:0], data_byte};
    end else if (byte_count < 17'd4) begin
      declared_length_next = {declared_length[7:0], data_byte};
    end else if (byte_count < 17'd8) begin
      cookie_shift_next = {cookie_shift[23:0], data_byte};
    end else if (walk_en) begin
      case (attr_phase)
        stun_pkg::PH_HDR: begin
          if (declared_length - attr_start < 16'd4) begin
            attr_phase_next = stun_pkg::PH_STOP;
          end else begin
            attr_header_shift_next = {attr_header_shift[23:0], data_byte};
            if ({1'b0, off} == {1'b0, attr_start} + 17'd3) begin
              pad      = ({1'b0, attr_header_shift_next[15:0]} + 17'd3) & ~17'd3;
              attr_end = {2'b0, attr_start} + 18'd4 + {1'b0, pad};
              if (attr_end > {2'b0, declared_length}) begin
                attr_phase_next = stun_pkg::PH_STOP;
              end else if (pad == 17'd0) begin
                rec_hit         = 1'b1;
                attr_start_next = attr_start + 16'd4;
              end else begin
                attr_phase_next     = stun_pkg::PH_VAL;
                attr_remaining_next = pad;
              end
            end
          end
        end
        stun_pkg::PH_VAL: begin
          attr_remaining_next = attr_remaining - 17'd1;
          if (attr_remaining_next == 17'd0) begin
            pad             = ({1'b0, attr_header_shift[15:0]} + 17'd3) & ~17'd3;
            attr_end        = {2'b0, attr_start} + 18'd4 + {1'b0, pad};
            rec_hit         = 1'b1;
            attr_start_next = attr_end[15:0];
            attr_phase_next = stun_pkg::PH_HDR;
          end
        end
        default: begin
        end
      endcase
    end

    // Only the first attribute of the message that carries the target type counts.
    rec_type = attr_header_shift_next[31:16];
    hit      = rec_hit && (rec_type == target_type) && !match_seen;
    if (hit) begin
      match_seen_next = 1'b1;
    end

    // The summary sees the state as this byte leaves it.
    hdr_ok_next = (type_word_next[15:8] < stun_pkg::TYPE0_LIMIT)
               && (cookie_shift_next == magic_cookie);
    if (byte_count_next < stun_pkg::HDR_BYTES) begin
      st = stun_pkg::ST_SHORT;
    end else if (!hdr_ok_next) begin
      st = stun_pkg::ST_BAD_HEADER;
    end else if (byte_count_next != stun_pkg::HDR_BYTES + {1'b0, declared_length_next}) begin
      st = stun_pkg::ST_LEN_MISM;
    end else if (!(attr_phase_next == stun_pkg::PH_HDR
                   && attr_start_next == declared_length_next)) begin
      st = stun_pkg::ST_UNTILED;
    end else begin
      st = stun_pkg::ST_OK;
    end

    push.rec_valid          = en && rec_hit;
    push.sum_valid          = en && end_of_message;
    push.rec.kind           = stun_pkg::KIND_ATTR;
    push.rec.attr_type      = rec_type;
    push.rec.attr_length    = attr_header_shift_next[15:0];
    push.rec.attr_offset    = attr_start;
    push.rec.optional_attr  = rec_type[15];
    push.rec.is_match       = hit;
    push.rec.stun_class     = {type_word_next[8], type_word_next[4]};
    push.rec.method_binding =
      (type_word_next & stun_pkg::METHOD_MASK) == stun_pkg::METHOD_BINDING;
    push.rec.status         = stun_pkg::ST_OK;
    push.rec.last           = !end_of_message;
    push.sum                = push.rec;
    push.sum.kind           = stun_pkg::KIND_SUMMARY;
    push.sum.attr_type      = '0;
    push.sum.attr_length    = '0;
    push.sum.attr_offset    = '0;
    push.sum.optional_attr  = 1'b0;
    push.sum.is_match       = 1'b0;
    push.sum.status         = st;
    push.sum.last           = 1'b1;

    if (end_of_message) begin
      byte_count_next        = '0;
      type_word_next         = '0;
      declared_length_next   = '0;
      cookie_shift_next      = '0;
      attr_phase_next        = stun_pkg::PH_HDR;
      attr_header_shift_next = '0;
      attr_remaining_next    = '0;
      attr_start_next        = '0;
      match_seen_next        = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count        <= '0;
      type_word         <= '0;
      declared_length   <= '0;
      cookie_shift      <= '0;
      attr_phase        <= stun_pkg::PH_HDR;
      attr_header_shift <= '0;
      attr_remaining    <= '0;
      attr_start        <= '0;
      match_seen        <= 1'b0;
    end else if (en) begin
      byte_count        <= byte_count_next;
      type_word         <= type_word_next;
      declared_length   <= declared_length_next;
      cookie_shift      <= cookie_shift_next;
      attr_phase        <= attr_phase_next;
      attr_header_shift <= attr_header_shift_next;
      attr_remaining    <= attr_remaining_next;
      attr_start        <= attr_start_next;
      match_seen        <= match_seen_next;
    end
  end

endmodule

@@ hw/rtl/stun_outq.sv @@
// ----------------------------------------------------------------------------
// STUN parser result queue
// Small queue that takes up to two results a cycle and hands out one.
// ----------------------------------------------------------------------------
module stun_outq (
  input  logic              clk,
  input  logic              rst,
  input  stun_pkg::push_t   push,
  input  logic              pop,
  output stun_pkg::result_t head,
  output logic              head_valid,
  output stun_pkg::qstat_t  qstat
);

  localparam int unsigned PtrW = $clog2(stun_pkg::Q_DEPTH);

  stun_pkg::result_t          slots [stun_pkg::Q_DEPTH];
  logic [PtrW-1:0]            wp, rp, wp_sum;
  logic [PtrW:0]              count, count_next;
  logic                       pop_ok;

  assign pop_ok     = pop && (count != '0);
  assign wp_sum     = wp + PtrW'(push.rec_valid);
  assign count_next = count + (PtrW+1)'(push.rec_valid) + (PtrW+1)'(push.sum_valid)
                    - (PtrW+1)'(pop_ok);
  assign head       = slots[rp];
  assign head_valid = (count != '0);
  assign qstat.count = count;

  always_ff @(posedge clk) begin
    if (push.rec_valid) begin
      slots[wp] <= push.rec;
    end
    if (push.sum_valid) begin
      slots[wp_sum] <= push.sum;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      wp    <= wp + PtrW'(push.rec_valid) + PtrW'(push.sum_valid);
      rp    <= rp + PtrW'(pop_ok);
      count <= count_next;
    end
  end

endmodule

@@ hw/rtl/stun_message_tlv_parser.sv @@
// ----------------------------------------------------------------------------
// STUN message TLV parser
// Checks a STUN header and walks its attributes, one datagram byte a cycle while the result queue has room.
// ----------------------------------------------------------------------------
// Usage: datagram bytes enter on the datagram channel in wire order, with
// end_of_message set on the final byte. Each accepted byte may give an
// attribute record (when the last padded byte of an attribute arrives) and,
// on the final byte, a summary with the message status; results leave on
// the result channel in that order, last marking the final one of a byte.
// A byte is accepted every cycle unless the input register is waiting on
// the queue: a byte is parsed while it sits in the input register, and its
// results are written into the queue as it moves on and are offered on the
// result channel from the queue. A four-entry result queue parts the two
// sides; the input register waits only while the queue lacks room for two
// results, so a receiver that stalls backs up into the datagram channel
// after a few bytes. Reset clears the parse state and the queue and loads
// the default cookie and target type; the user writes them over the APB port
// only while the block is idle, and the block itself does not enforce this.
// ----------------------------------------------------------------------------
module stun_message_tlv_parser (
  input  logic              clk,
  input  logic              rst,
  stun_in_if.sink           datagram,
  stun_out_if.source        result,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  // Configuration registers.
  logic [31:0] magic_cookie;
  logic [15:0] target_type;

  // Input register.
  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       s1_eom;
  logic       s1_fire;

  stun_pkg::push_t   push;
  stun_pkg::result_t head;
  stun_pkg::qstat_t  qstat;
  logic              head_valid;

  // The APB write lands at the access phase; pready is tied high.
  assign pready = 1'b1;
  assign prdata = (paddr[2] == stun_pkg::REG_TARGET) ? {16'b0, target_type} : magic_cookie;

  always_ff @(posedge clk) begin
    if (rst) begin
      magic_cookie <= 32'h2112A442;
      target_type  <= 16'd6;
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == stun_pkg::REG_COOKIE) begin
        magic_cookie <= pwdata;
      end else begin
        target_type <= pwdata[15:0];
      end
    end
  end

  // The held byte moves on only when the queue can take both of its results.
  assign s1_fire        = s1_valid
                       && (qstat.count <= ($clog2(stun_pkg::Q_DEPTH)+1)'(stun_pkg::Q_DEPTH - 2));
  assign datagram.ready = !s1_valid || s1_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (datagram.valid && datagram.ready) begin
      s1_valid <= 1'b1;
    end else if (s1_fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (datagram.valid && datagram.ready) begin
      s1_byte <= datagram.data_byte;
      s1_eom  <= datagram.end_of_message;
    end
  end

  stun_core u_core (
    .clk            (clk),
    .rst            (rst),
    .en             (s1_fire),
    .data_byte      (s1_byte),
    .end_of_message (s1_eom),
    .magic_cookie   (magic_cookie),
    .target_type    (target_type),
    .push           (push)
  );

  stun_outq u_outq (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .pop        (result.ready),
    .head       (head),
    .head_valid (head_valid),
    .qstat      (qstat)
  );

  assign result.valid          = head_valid;
  assign result.kind           = head.kind;
  assign result.attr_type      = head.attr_type;
  assign result.attr_length    = head.attr_length;
  assign result.attr_offset    = head.attr_offset;
  assign result.optional_attr  = head.optional_attr;
  assign result.is_match       = head.is_match;
  assign result.stun_class     = head.stun_class;
  assign result.method_binding = head.method_binding;
  assign result.status         = head.status;
  assign result.last           = head.last;

  // The queue never holds more results than it has entries.
  a_q_bound: assert property (@(posedge clk) disable iff (rst)
    qstat.count <= ($clog2(stun_pkg::Q_DEPTH)+1)'(stun_pkg::Q_DEPTH))
    else $error("result queue overfilled");

  // A byte held back by a full queue keeps its value.
  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s1_fire) |=> (s1_valid && $stable(s1_byte) && $stable(s1_eom)))
    else $error("held input byte changed");

  // Results only appear after a parsed byte has filled the queue.
  a_no_ghost: assert property (@(posedge clk) disable iff (rst)
    (!push.rec_valid && !push.sum_valid && qstat.count == '0) |=> !result.valid)
    else $error("result offered from an empty queue");

endmodule

@@ test/stun_message_tlv_parser_tb.sv @@
// ----------------------------------------------------------------------------
// STUN message TLV parser testbench
// Streams STUN datagrams byte by byte into the parser, predicts every
// attribute record and end-of-message summary, and checks each result word
// against the prediction while both channels idle and stall at random.
// ----------------------------------------------------------------------------
module stun_message_tlv_parser_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Register values after reset.
  localparam logic [31:0] COOKIE_RESET = 32'h2112_A442;
  localparam logic [15:0] TARGET_RESET = 16'd6;
  localparam int unsigned PHASE_BYTES = 212;
  localparam int unsigned N_PHASES = 8;

  typedef logic [7:0] byte_q_t[$];

  typedef struct {
    logic [7:0]  data;
    logic        eom;
    int unsigned gap;
  } dgram_byte_t;

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  stun_in_if  datagram_ch ();
  stun_out_if result_ch ();

  stun_message_tlv_parser u_top (
    .clk      (clk),
    .rst      (rst),
    .datagram (datagram_ch),
    .result   (result_ch),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // Bytes waiting to be offered, and the parse results the block owes us.
  dgram_byte_t         datagram_bytes[$];
  stun_pkg::result_t   parse_results_q[$];

  // Our own copy of the configuration registers.
  logic [31:0] cfg_cookie;
  logic [15:0] cfg_target;

  // Our own copy of the parse state.
  logic [16:0]      pr_count;
  logic [15:0]      pr_type;
  logic [15:0]      pr_len;
  logic [31:0]      pr_cookie;
  stun_pkg::phase_t pr_phase;
  logic [31:0]      pr_ahdr;
  logic [16:0]      pr_remain;
  logic [15:0]      pr_start;
  logic             pr_matched;

  int unsigned errors;
  int unsigned gap_cnt;
  int unsigned hold_cnt;
  int unsigned out_stall;
  int unsigned phase_bytes;
  bit          idle_in;
  bit          idle_out;

  // --------------------------------------------------------------------------
  // Clock and reset.
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    rst = 1'b1;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
  end

  // The slowest correct run stays far below this; reaching it means a hang.
  initial begin
    #20_000_000;
    $display("Regression FAIL");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    if (errors < 40) $display("MISMATCH: %s", msg);
    errors++;
  endtask

  // --------------------------------------------------------------------------
  // Predictor.
  // --------------------------------------------------------------------------
  function automatic void clear_parse_state();
    pr_count = '0;
    pr_type = '0;
    pr_len = '0;
    pr_cookie = '0;
    pr_phase = stun_pkg::PH_HDR;
    pr_ahdr = '0;
    pr_remain = '0;
    pr_start = '0;
    pr_matched = 1'b0;
  endfunction

  function automatic bit header_good();
    return pr_type[15:8] < stun_pkg::TYPE0_LIMIT && pr_cookie == cfg_cookie;
  endfunction

  // Record for the attribute whose header sits in pr_ahdr. Only the first
  // attribute of the target type in a message is flagged.
  function automatic stun_pkg::result_t attr_record();
    stun_pkg::result_t r;
    r = '0;
    r.kind = stun_pkg::KIND_ATTR;
    r.attr_type = pr_ahdr[31:16];
    r.attr_length = pr_ahdr[15:0];
    r.attr_offset = pr_start;
    r.optional_attr = pr_ahdr[31];
    if (pr_ahdr[31:16] == cfg_target && !pr_matched) begin
      r.is_match = 1'b1;
      pr_matched = 1'b1;
    end
    r.stun_class = {pr_type[8], pr_type[4]};
    r.method_binding = (pr_type & stun_pkg::METHOD_MASK) == stun_pkg::METHOD_BINDING;
    r.status = stun_pkg::ST_OK;
    return r;
  endfunction

  // Advances the parse by one accepted byte and queues whatever results the
  // byte causes: an attribute record, a summary, or both in that order.
  function automatic void parse_byte(input logic [7:0] b, input logic eom);
    logic [16:0]       idx;
    logic [31:0]       off;
    logic [31:0]       padded;
    stun_pkg::result_t rec;
    stun_pkg::result_t sum;
    bit                got_rec;
    idx = pr_count;
    got_rec = 0;
    rec = '0;
    if (pr_count < stun_pkg::COUNT_MAX) pr_count = pr_count + 17'd1;

    if (idx < 17'd2) begin
      pr_type = {pr_type[7:0], b};
    end else if (idx < 17'd4) begin
      pr_len = {pr_len[7:0], b};
    end else if (idx < 17'd8) begin
      pr_cookie = {pr_cookie[23:0], b};
    end else if (idx >= stun_pkg::HDR_BYTES && idx < stun_pkg::HDR_BYTES + 17'(pr_len)
                 && header_good()) begin
      off = 32'(idx - stun_pkg::HDR_BYTES);
      case (pr_phase)
        stun_pkg::PH_HDR: begin
          // Fewer than four payload bytes left cannot hold a header.
          if (32'(pr_len) - 32'(pr_start) < 32'd4) begin
            pr_phase = stun_pkg::PH_STOP;
          end else begin
            pr_ahdr = {pr_ahdr[23:0], b};
            if (off - 32'(pr_start) == 32'd3) begin
              padded = (32'(pr_ahdr[15:0]) + 32'd3) & ~32'd3;
              if (32'(pr_start) + 32'd4 + padded > 32'(pr_len)) begin
                pr_phase = stun_pkg::PH_STOP;
              end else if (padded == 32'd0) begin
                got_rec = 1;
                rec = attr_record();
                pr_start = pr_start + 16'd4;
              end else begin
                pr_phase = stun_pkg::PH_VAL;
                pr_remain = padded[16:0];
              end
            end
          end
        end
        stun_pkg::PH_VAL: begin
          pr_remain = pr_remain - 17'd1;
          if (pr_remain == '0) begin
            padded = (32'(pr_ahdr[15:0]) + 32'd3) & ~32'd3;
            got_rec = 1;
            rec = attr_record();
            pr_start = 16'(32'(pr_start) + 32'd4 + padded);
            pr_phase = stun_pkg::PH_HDR;
          end
        end
        default: ;
      endcase
    end

    if (got_rec) begin
      rec.last = !eom;
      parse_results_q.insert(parse_results_q.size(), rec);
    end

    if (eom) begin
      sum = '0;
      sum.kind = stun_pkg::KIND_SUMMARY;
      sum.stun_class = {pr_type[8], pr_type[4]};
      sum.method_binding = (pr_type & stun_pkg::METHOD_MASK) == stun_pkg::METHOD_BINDING;
      if (pr_count < stun_pkg::HDR_BYTES)
        sum.status = stun_pkg::ST_SHORT;
      else if (!header_good())
        sum.status = stun_pkg::ST_BAD_HEADER;
      else if (pr_count != stun_pkg::HDR_BYTES + 17'(pr_len))
        sum.status = stun_pkg::ST_LEN_MISM;
      else if (!(pr_phase == stun_pkg::PH_HDR && pr_start == pr_len))
        sum.status = stun_pkg::ST_UNTILED;
      else
        sum.status = stun_pkg::ST_OK;
      sum.last = 1'b1;
      parse_results_q.insert(parse_results_q.size(), sum);
      clear_parse_state();
    end
  endfunction

  // --------------------------------------------------------------------------
  // Datagram driver: offers the queued bytes, each after its own idle gap.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      datagram_ch.valid <= 1'b0;
      datagram_ch.data_byte <= '0;
      datagram_ch.end_of_message <= 1'b0;
      gap_cnt <= 0;
    end else if (!datagram_ch.valid || datagram_ch.ready) begin
      if (datagram_bytes.size() == 0) begin
        datagram_ch.valid <= 1'b0;
      end else if (gap_cnt < datagram_bytes[0].gap) begin
        datagram_ch.valid <= 1'b0;
        gap_cnt <= gap_cnt + 1;
      end else begin
        datagram_ch.valid <= 1'b1;
        datagram_ch.data_byte <= datagram_bytes[0].data;
        datagram_ch.end_of_message <= datagram_bytes[0].eom;
        void'(datagram_bytes.pop_front());
        gap_cnt <= 0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result receiver: after each accepted word it may hold ready low for a
  // while, which pushes back through the result queue into the datagram side.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      result_ch.ready <= 1'b1;
      hold_cnt <= 0;
    end else if (hold_cnt != 0) begin
      hold_cnt <= hold_cnt - 1;
      if (hold_cnt == 1) result_ch.ready <= 1'b1;
    end else if (result_ch.valid && result_ch.ready) begin
      out_stall = idle_out ? $urandom_range(0, 18) : 0;
      if (out_stall != 0) begin
        result_ch.ready <= 1'b0;
        hold_cnt <= out_stall;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: every accepted byte feeds the predictor, and every accepted
  // result word is checked against the oldest prediction. A result never
  // leaves in the cycle of its own byte, so the order of the two is safe.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    stun_pkg::result_t got;
    stun_pkg::result_t want;
    if (rst) begin
      clear_parse_state();
    end else begin
      if (datagram_ch.valid && datagram_ch.ready)
        parse_byte(datagram_ch.data_byte, datagram_ch.end_of_message);
      if (result_ch.valid && result_ch.ready) begin
        got = {result_ch.kind, result_ch.attr_type, result_ch.attr_length,
               result_ch.attr_offset, result_ch.optional_attr, result_ch.is_match,
               result_ch.stun_class, result_ch.method_binding, result_ch.status,
               result_ch.last};
        if (parse_results_q.size() == 0) begin
          report_mismatch($sformatf("result word %h with nothing expected", got));
        end else begin
          want = parse_results_q.pop_front();
          if (got.kind !== want.kind)
            report_mismatch($sformatf("kind %h, expected %h", got.kind, want.kind));
          if (got.attr_type !== want.attr_type)
            report_mismatch($sformatf("attr_type %h, expected %h",
                                      got.attr_type, want.attr_type));
          if (got.attr_length !== want.attr_length)
            report_mismatch($sformatf("attr_length %h, expected %h",
                                      got.attr_length, want.attr_length));
          if (got.attr_offset !== want.attr_offset)
            report_mismatch($sformatf("attr_offset %h, expected %h",
                                      got.attr_offset, want.attr_offset));
          if (got.optional_attr !== want.optional_attr)
            report_mismatch($sformatf("optional_attr %h, expected %h",
                                      got.optional_attr, want.optional_attr));
          if (got.is_match !== want.is_match)
            report_mismatch($sformatf("is_match %h, expected %h",
                                      got.is_match, want.is_match));
          if (got.stun_class !== want.stun_class)
            report_mismatch($sformatf("stun_class %h, expected %h",
                                      got.stun_class, want.stun_class));
          if (got.method_binding !== want.method_binding)
            report_mismatch($sformatf("method_binding %h, expected %h",
                                      got.method_binding, want.method_binding));
          if (got.status !== want.status)
            report_mismatch($sformatf("status %h, expected %h", got.status, want.status));
          if (got.last !== want.last)
            report_mismatch($sformatf("last %h, expected %h", got.last, want.last));
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Configuration access over APB: a setup phase, then an access phase.
  // --------------------------------------------------------------------------
  task automatic read_register(input logic idx, output logic [31:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= {idx, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    value = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // Writes a register, mirrors it in our copy, and reads it back.
  task automatic write_register(input logic idx, input logic [31:0] value);
    logic [31:0] rd;
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == stun_pkg::REG_COOKIE) cfg_cookie = value;
    else cfg_target = value[15:0];
    read_register(idx, rd);
    if (rd !== (idx == stun_pkg::REG_COOKIE ? cfg_cookie : {16'd0, cfg_target}))
      report_mismatch($sformatf("register %0d reads %h after writing %h", idx, rd, value));
  endtask

  // --------------------------------------------------------------------------
  // Stimulus helpers.
  // --------------------------------------------------------------------------
  function automatic void add_byte(input logic [7:0] b, input logic eom);
    dgram_byte_t item;
    item.data = b;
    item.eom = eom;
    item.gap = idle_in ? $urandom_range(0, 18) : 0;
    datagram_bytes.insert(datagram_bytes.size(), item);
    phase_bytes++;
  endfunction

  function automatic void send_message(input byte_q_t m);
    foreach (m[i]) add_byte(m[i], i == m.size() - 1);
  endfunction

  // Header with the given type word, declared length and cookie, and a
  // random transaction id.
  function automatic byte_q_t stun_header(input logic [15:0] tw, input logic [15:0] dlen,
                                          input logic [31:0] cookie);
    byte_q_t h;
    h = '{tw[15:8], tw[7:0], dlen[15:8], dlen[7:0],
          cookie[31:24], cookie[23:16], cookie[15:8], cookie[7:0]};
    repeat (12) h.insert(h.size(), 8'($urandom));
    return h;
  endfunction

  // One random datagram. Most are well formed with random attributes; the
  // rest carry one defect each: a bad first type byte, a wrong cookie, a
  // declared length that disagrees with the bytes sent, an attribute length
  // that breaks the tiling, one to seven stray bytes after the attributes, or are
  // too short or plain noise.
  function automatic void make_message();
    byte_q_t     m;
    byte_q_t     body;
    int unsigned starts[$];
    int unsigned mode;
    int unsigned alen;
    int unsigned pick;
    int unsigned k;
    int unsigned j;
    logic [15:0] atype;
    logic [15:0] tw;
    logic [15:0] dlen;
    logic [15:0] bad_len;
    logic [31:0] cookie;
    mode = $urandom_range(0, 99);

    if (mode < 6) begin
      k = $urandom_range(1, 19);
      repeat (k) m.insert(m.size(), 8'($urandom));
      send_message(m);
      return;
    end
    if (mode < 12) begin
      k = $urandom_range(20, 48);
      repeat (k) m.insert(m.size(), 8'($urandom));
      send_message(m);
      return;
    end

    repeat ($urandom_range(0, 4)) begin
      pick = $urandom_range(0, 9);
      if (pick < 3) atype = cfg_target;
      else if (pick == 3) atype = 16'hFFFF;
      else if (pick == 4) atype = 16'h0000;
      else if (pick == 5) atype = 16'h8000 | 16'($urandom);
      else atype = 16'($urandom);
      alen = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 8);
      starts.insert(starts.size(), body.size());
      body.insert(body.size(), atype[15:8]);
      body.insert(body.size(), atype[7:0]);
      body.insert(body.size(), 8'(alen >> 8));
      body.insert(body.size(), 8'(alen));
      repeat ((alen + 3) & ~3) body.insert(body.size(), 8'($urandom));
    end

    // Tiling defects live inside the declared length.
    if (mode < 20 && starts.size() != 0) begin
      j = starts[$urandom_range(0, starts.size() - 1)];
      bad_len = $urandom_range(0, 1) ? 16'hFFFF : 16'($urandom_range(0, 64));
      body[j + 2] = bad_len[15:8];
      body[j + 3] = bad_len[7:0];
    end else if (mode < 26) begin
      repeat ($urandom_range(1, 7)) body.insert(body.size(), 8'($urandom));
    end
    dlen = 16'(body.size());
    if (mode >= 40 && mode < 43) dlen = 16'($urandom);

    // Type word: binding in any class a third of the time.
    if ($urandom_range(0, 2) == 0)
      tw = stun_pkg::METHOD_BINDING | {7'd0, 1'($urandom), 3'd0, 1'($urandom), 4'd0};
    else
      tw = {8'($urandom_range(0, 2)), 8'($urandom)};
    if (mode >= 26 && mode < 30) tw[15:8] = 8'($urandom_range(3, 255));
    cookie = cfg_cookie;
    if (mode >= 30 && mode < 34) cookie = cookie ^ (32'd1 << $urandom_range(0, 31));

    m = stun_header(tw, dlen, cookie);
    foreach (body[i]) m.insert(m.size(), body[i]);

    // Sent length disagrees with the declared one.
    if (mode >= 34 && mode < 40) begin
      k = $urandom_range(1, 5);
      if ($urandom_range(0, 1)) repeat (k) m.insert(m.size(), 8'($urandom));
      else repeat (k) void'(m.pop_back());
    end
    send_message(m);
  endfunction

  // Waits until every byte is taken and every result has arrived, then lets
  // the block run on idle, since a byte need not cause a result.
  task automatic wait_quiet();
    int unsigned guard;
    guard = 0;
    while ((datagram_bytes.size() != 0 || datagram_ch.valid || parse_results_q.size() != 0)
           && guard < 400000) begin
      @(posedge clk);
      guard++;
    end
    repeat (8) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Test sequence.
  // --------------------------------------------------------------------------
  initial begin : sequencer
    logic [31:0] rd;
    byte_q_t     m;
    errors = 0;
    idle_in = 1;
    idle_out = 1;
    cfg_cookie = COOKIE_RESET;
    cfg_target = TARGET_RESET;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    @(negedge rst);

    // Registers come out of reset with their defaults.
    read_register(stun_pkg::REG_COOKIE, rd);
    if (rd !== COOKIE_RESET) report_mismatch($sformatf("cookie after reset %h", rd));
    read_register(stun_pkg::REG_TARGET, rd);
    if (rd[15:0] !== TARGET_RESET) report_mismatch($sformatf("target after reset %h", rd));

    // Directed datagrams: a lone byte, a three-byte stub of all ones, and the
    // smallest valid message, a binding request with no attributes.
    m = '{8'hFF};
    send_message(m);
    m = '{8'hFF, 8'hFF, 8'hFF};
    send_message(m);
    m = stun_header(stun_pkg::METHOD_BINDING, 16'd0, cfg_cookie);
    send_message(m);
    wait_quiet();

    // Random phases, each writing the registers and using one of four idling mixes.
    for (int ph = 0; ph < N_PHASES; ph++) begin
      case (ph)
        0: begin
          write_register(stun_pkg::REG_COOKIE, COOKIE_RESET);
          write_register(stun_pkg::REG_TARGET, 32'(TARGET_RESET));
        end
        1: begin
          write_register(stun_pkg::REG_COOKIE, 32'h0000_0000);
          write_register(stun_pkg::REG_TARGET, 32'h0000_0000);
        end
        2: begin
          write_register(stun_pkg::REG_COOKIE, 32'hFFFF_FFFF);
          write_register(stun_pkg::REG_TARGET, 32'h0000_FFFF);
        end
        default: begin
          write_register(stun_pkg::REG_COOKIE, $urandom);
          write_register(stun_pkg::REG_TARGET, 32'($urandom_range(0, 65535)));
        end
      endcase
      idle_in = (ph % 4 != 1) && (ph % 4 != 3);
      idle_out = (ph % 4 != 1) && (ph % 4 != 2);
      phase_bytes = 0;
      while (phase_bytes < PHASE_BYTES) make_message();
      wait_quiet();
    end

    if (parse_results_q.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", parse_results_q.size()));
    if (errors == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
